@@ rtl/mrf_pkg.sv @@
// package for the modbus rtu request framer
// holds frame constants, register map and the crc-16 byte update
// no dependencies
package mrf_pkg;

   localparam int ByteWidth    = 8;
   localparam int CrcWidth     = 16;
   localparam int PosWidth     = 3;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [CrcWidth-1:0]  CrcInit          = 16'hFFFF;
   localparam logic [CrcWidth-1:0]  CrcPoly          = 16'hA001;
   localparam logic [ByteWidth-1:0] SlaveAddrReset   = 8'h7B;

   localparam logic [0:0] CsrSlaveAddrIdx = 1'b0;

   localparam logic [PosWidth-1:0] PosSlaveAddr = 3'd0;
   localparam logic [PosWidth-1:0] PosFunction  = 3'd1;
   localparam logic [PosWidth-1:0] PosRegHigh   = 3'd2;
   localparam logic [PosWidth-1:0] PosRegLow    = 3'd3;
   localparam logic [PosWidth-1:0] PosZero      = 3'd4;
   localparam logic [PosWidth-1:0] PosCount     = 3'd5;
   localparam logic [PosWidth-1:0] PosCrcLow    = 3'd6;
   localparam logic [PosWidth-1:0] PosCrcHigh   = 3'd7;

   function automatic logic [CrcWidth-1:0] crc_update(
      input logic [CrcWidth-1:0]  crc_value,
      input logic [ByteWidth-1:0] data_byte
   );
      logic [CrcWidth-1:0] c;
      c = crc_value ^ {{(CrcWidth-ByteWidth){1'b0}}, data_byte};
      for (int b = 0; b < ByteWidth; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/mrf_if.sv @@
// channel interfaces for the modbus rtu request framer
// depends on mrf_pkg for byte width
interface mrf_req_if;
   logic                         valid;
   logic                         ready;
   logic [mrf_pkg::ByteWidth-1:0] function_code;
   logic [mrf_pkg::ByteWidth-1:0] register_high;
   logic [mrf_pkg::ByteWidth-1:0] register_low;
   logic [mrf_pkg::ByteWidth-1:0] count_or_value;

   modport source (output valid, function_code, register_high, register_low,
                   count_or_value, input ready);
   modport sink (input valid, function_code, register_high, register_low,
                 count_or_value, output ready);
endinterface

interface mrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mrf_pkg::ByteWidth-1:0] frame_byte;
   logic                         last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

@@ rtl/mrf_csr.sv @@
// apb-style register block holding the slave address
// depends on mrf_pkg
module mrf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mrf_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [mrf_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [mrf_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic [mrf_pkg::ByteWidth-1:0]      slave_address
);

   logic [mrf_pkg::ByteWidth-1:0] slave_address_ff;
   logic [mrf_pkg::ByteWidth-1:0] slave_address_in;
   logic                          reg_index;
   logic                          write_hit;

   assign reg_index = csr_paddr[2];
   assign write_hit = csr_psel && csr_penable && csr_pwrite
                      && (reg_index == mrf_pkg::CsrSlaveAddrIdx);

   always_comb begin
      slave_address_in = slave_address_ff;
      if (write_hit) begin
         slave_address_in = csr_pwdata[mrf_pkg::ByteWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= mrf_pkg::SlaveAddrReset;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == mrf_pkg::CsrSlaveAddrIdx) begin
         csr_prdata = {{(mrf_pkg::CsrDataWidth-mrf_pkg::ByteWidth){1'b0}},
                       slave_address_ff};
      end
   end

   assign csr_pready    = 1'b1;
   assign slave_address = slave_address_ff;

endmodule

@@ rtl/modbus_rtu_request_framer.sv @@
// top level of the modbus rtu request framer: request buffer, byte serializer, crc
// depends on mrf_pkg, mrf_if and mrf_csr
//
//   channel | direction | word                                       | handshake
//   req     | in        | function, register high/low, count/value  | valid/ready
//   rsp     | out       | frame byte, last byte flag                 | valid/ready
//   csr     | in        | slave address register                     | apb, pready high
//
// one request gives eight words, one per cycle while rsp does not stall
// the byte serializer updates its running crc one byte per cycle, unless rsp stalls
// a one-deep request buffer takes the next request while a frame is sent
// rsp stalls hold the output register and freeze the serializer
// synchronous reset empties the buffer and the serializer, slave address to 0x7b
module modbus_rtu_request_framer (
   input  logic                               clock,
   input  logic                               reset,
   mrf_req_if.sink                            req,
   mrf_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mrf_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [mrf_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [mrf_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);

   logic [mrf_pkg::ByteWidth-1:0] slave_address;

   logic                          in_valid_ff,  in_valid_in;
   logic [mrf_pkg::ByteWidth-1:0] in_fc_ff,     in_fc_in;
   logic [mrf_pkg::ByteWidth-1:0] in_rh_ff,     in_rh_in;
   logic [mrf_pkg::ByteWidth-1:0] in_rl_ff,     in_rl_in;
   logic [mrf_pkg::ByteWidth-1:0] in_cv_ff,     in_cv_in;

   logic                          busy_ff,      busy_in;
   logic [mrf_pkg::PosWidth-1:0]  idx_ff,       idx_in;
   logic [mrf_pkg::ByteWidth-1:0] fr_addr_ff,   fr_addr_in;
   logic [mrf_pkg::ByteWidth-1:0] fr_fc_ff,     fr_fc_in;
   logic [mrf_pkg::ByteWidth-1:0] fr_rh_ff,     fr_rh_in;
   logic [mrf_pkg::ByteWidth-1:0] fr_rl_ff,     fr_rl_in;
   logic [mrf_pkg::ByteWidth-1:0] fr_cv_ff,     fr_cv_in;
   logic [mrf_pkg::CrcWidth-1:0]  crc_ff,       crc_in;

   logic                          out_valid_ff, out_valid_in;
   logic [mrf_pkg::ByteWidth-1:0] out_byte_ff,  out_byte_in;
   logic                          out_last_ff,  out_last_in;

   logic                          req_take;
   logic                          advance;
   logic                          frame_done;
   logic                          load;
   logic [mrf_pkg::ByteWidth-1:0] cur_byte;

   mrf_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .slave_address (slave_address)
   );

   assign req.ready  = !in_valid_ff;
   assign req_take   = req.valid && req.ready;
   assign advance    = busy_ff && (!out_valid_ff || rsp.ready);
   assign frame_done = advance && (idx_ff == mrf_pkg::PosCrcHigh);
   assign load       = in_valid_ff && (!busy_ff || frame_done);

   always_comb begin
      case (idx_ff)
         mrf_pkg::PosSlaveAddr: cur_byte = fr_addr_ff;
         mrf_pkg::PosFunction:  cur_byte = fr_fc_ff;
         mrf_pkg::PosRegHigh:   cur_byte = fr_rh_ff;
         mrf_pkg::PosRegLow:    cur_byte = fr_rl_ff;
         mrf_pkg::PosZero:      cur_byte = '0;
         mrf_pkg::PosCount:     cur_byte = fr_cv_ff;
         mrf_pkg::PosCrcLow:    cur_byte = crc_ff[mrf_pkg::ByteWidth-1:0];
         mrf_pkg::PosCrcHigh:   cur_byte = crc_ff[mrf_pkg::CrcWidth-1:mrf_pkg::ByteWidth];
         default:               cur_byte = '0;
      endcase
   end

   // request buffer
   always_comb begin
      in_valid_in = in_valid_ff;
      in_fc_in    = in_fc_ff;
      in_rh_in    = in_rh_ff;
      in_rl_in    = in_rl_ff;
      in_cv_in    = in_cv_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_fc_in    = req.function_code;
         in_rh_in    = req.register_high;
         in_rl_in    = req.register_low;
         in_cv_in    = req.count_or_value;
      end
   end

   // serializer with running crc
   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      fr_addr_in = fr_addr_ff;
      fr_fc_in   = fr_fc_ff;
      fr_rh_in   = fr_rh_ff;
      fr_rl_in   = fr_rl_ff;
      fr_cv_in   = fr_cv_ff;
      crc_in     = crc_ff;
      if (advance) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff < mrf_pkg::PosCrcLow) begin
            crc_in = mrf_pkg::crc_update(crc_ff, cur_byte);
         end
         if (frame_done) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in    = 1'b1;
         idx_in     = mrf_pkg::PosSlaveAddr;
         fr_addr_in = slave_address;
         fr_fc_in   = in_fc_ff;
         fr_rh_in   = in_rh_ff;
         fr_rl_in   = in_rl_ff;
         fr_cv_in   = in_cv_ff;
         crc_in     = mrf_pkg::CrcInit;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = (idx_ff == mrf_pkg::PosCrcHigh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= mrf_pkg::PosSlaveAddr;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_fc_ff    <= in_fc_in;
      in_rh_ff    <= in_rh_in;
      in_rl_ff    <= in_rl_in;
      in_cv_ff    <= in_cv_in;
      fr_addr_ff  <= fr_addr_in;
      fr_fc_ff    <= fr_fc_in;
      fr_rh_ff    <= fr_rh_in;
      fr_rl_ff    <= fr_rl_in;
      fr_cv_ff    <= fr_cv_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.frame_byte = out_byte_ff;
   assign rsp.last_byte  = out_last_ff;

`ifndef SYNTHESIS
   a_last_on_crc_high: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (out_valid_ff && out_last_ff))
      else $error("last byte flag missing after crc high byte");

   a_buffer_drains: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !busy_ff) |=> busy_ff)
      else $error("buffered request not loaded into idle serializer");

   a_crc_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (idx_ff == mrf_pkg::PosSlaveAddr)) |-> (crc_ff == mrf_pkg::CrcInit))
      else $error("crc not at initial value at frame start");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (idx_ff == mrf_pkg::PosSlaveAddr))
      else $error("byte index not rewound while idle");
`endif

endmodule

@@ test/tb_modbus_rtu_request_framer.sv @@
// testbench for modbus_rtu_request_framer: directed and random requests under random
// stalls on both channels, slave address rewritten over apb between idle phases
// depends on mrf_pkg, mrf_if and the framer rtl; frames and crc are rebuilt in the bench
module tb_modbus_rtu_request_framer;

   localparam logic [7:0]  AddrAtReset      = 8'h7B;
   localparam logic [15:0] CrcSeed          = 16'hFFFF;
   localparam logic [15:0] CrcReflectedPoly = 16'hA001;
   localparam int          FrameBytes       = 8;
   localparam int          CrcCoveredBytes  = 6;
   localparam int          RandomPerPhase   = 60;
   localparam int          AddressPhases    = 6;
   localparam int          SettleCycles     = 10;

   localparam logic [mrf_pkg::CsrAddrWidth-1:0] SlaveAddrOffset =
      {mrf_pkg::CsrSlaveAddrIdx, 2'b00};
   localparam logic [mrf_pkg::CsrAddrWidth-1:0] SpareRegOffset  = 3'd4;

   typedef struct packed {
      logic [7:0] function_code;
      logic [7:0] register_high;
      logic [7:0] register_low;
      logic [7:0] count_or_value;
   } request_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_word_type;

   localparam logic [7:0] CommonFunctionCodes [8] = '{
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0F, 8'h10
   };

   localparam request_type DirectedRequests [14] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h03, 8'h00, 8'h00, 8'h01},
      '{8'h03, 8'hFF, 8'hFF, 8'hFF},
      '{8'h04, 8'h00, 8'h10, 8'h7D},
      '{8'h06, 8'h00, 8'h01, 8'h00},
      '{8'h06, 8'h12, 8'h34, 8'hFF},
      '{8'h01, 8'h00, 8'h13, 8'h25},
      '{8'h02, 8'h00, 8'hC4, 8'h16},
      '{8'h05, 8'h00, 8'hAC, 8'hFF},
      '{8'h0F, 8'h00, 8'h13, 8'h0A},
      '{8'h10, 8'h00, 8'h01, 8'h02},
      '{8'h80, 8'h55, 8'hAA, 8'h80},
      '{8'h7F, 8'hAA, 8'h55, 8'h7F}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [mrf_pkg::CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [mrf_pkg::CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [mrf_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   mrf_req_if req_if ();
   mrf_rsp_if rsp_if ();

   request_type    pending_requests [$];
   frame_word_type expected_words [$];
   request_type    next_request;
   frame_word_type oldest_word;
   logic [7:0]     slave_address;

   int queued_count = 0;
   int sent_count   = 0;
   int error_count  = 0;
   int req_hold     = 0;
   int rsp_hold     = 0;
   bit req_steady   = 1'b0;
   bit rsp_steady   = 1'b0;

   modbus_rtu_request_framer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_wait(inout bit steady);
      if ($urandom_range(0, 24) == 0) steady = ~steady;
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [7:0] skewed_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.function_code  = $urandom_range(0, 1) ? CommonFunctionCodes[$urandom_range(0, 7)]
                                                : skewed_byte();
      rq.register_high  = skewed_byte();
      rq.register_low   = skewed_byte();
      rq.count_or_value = skewed_byte();
      return rq;
   endfunction

   // builds the frame for one request and queues its words with the crc appended
   function automatic void push_request_frame(input request_type rq);
      logic [7:0]  frame [FrameBytes];
      logic [15:0] crc;
      frame[0] = slave_address;
      frame[1] = rq.function_code;
      frame[2] = rq.register_high;
      frame[3] = rq.register_low;
      frame[4] = 8'h00;
      frame[5] = rq.count_or_value;
      crc = CrcSeed;
      for (int k = 0; k < CrcCoveredBytes; k++) begin
         crc = crc ^ {8'h00, frame[k]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CrcReflectedPoly) : (crc >> 1);
      end
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int k = 0; k < FrameBytes; k++) begin
         expected_words.push_back(frame_word_type'{frame[k], k == FrameBytes - 1});
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic queue_request(input request_type rq);
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_request(random_request());
   endtask

   task automatic wait_idle();
      while (sent_count != queued_count || expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en,
                             input logic [mrf_pkg::CsrAddrWidth-1:0] offset,
                             input logic [mrf_pkg::CsrDataWidth-1:0] wdata,
                             output logic [mrf_pkg::CsrDataWidth-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= offset;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (write_en && offset == SlaveAddrOffset) slave_address = wdata[7:0];
   endtask

   task automatic check_slave_address();
      logic [mrf_pkg::CsrDataWidth-1:0] readback;
      csr_access(1'b0, SlaveAddrOffset, '0, readback);
      if (readback[7:0] !== slave_address) begin
         report_mismatch($sformatf("slave address read %h, want %h",
                                   readback[7:0], slave_address));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            push_request_frame(request_type'{req_if.function_code, req_if.register_high,
                                             req_if.register_low, req_if.count_or_value});
            sent_count++;
            req_hold = pick_wait(req_steady);
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               req_if.valid          <= 1'b1;
               req_if.function_code  <= next_request.function_code;
               req_if.register_high  <= next_request.register_high;
               req_if.register_low   <= next_request.register_low;
               req_if.count_or_value <= next_request.count_or_value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // frame word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %h last %b with nothing expected",
                                         rsp_if.frame_byte, rsp_if.last_byte));
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_if.frame_byte !== oldest_word.frame_byte) begin
                  report_mismatch($sformatf("frame_byte %h, want %h",
                                            rsp_if.frame_byte, oldest_word.frame_byte));
               end
               if (rsp_if.last_byte !== oldest_word.last_byte) begin
                  report_mismatch($sformatf("last_byte %b, want %b",
                                            rsp_if.last_byte, oldest_word.last_byte));
               end
            end
            rsp_hold = pick_wait(rsp_steady);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] upper;
      logic [7:0]  address_value;
      logic [mrf_pkg::CsrDataWidth-1:0] unused;
      req_if.valid          = 1'b0;
      req_if.function_code  = '0;
      req_if.register_high  = '0;
      req_if.register_low   = '0;
      req_if.count_or_value = '0;
      rsp_if.ready          = 1'b0;
      slave_address         = AddrAtReset;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      check_slave_address();
      foreach (DirectedRequests[i]) queue_request(DirectedRequests[i]);
      queue_random(RandomPerPhase);
      wait_idle();

      for (int p = 0; p < AddressPhases; p++) begin
         case (p)
            0: address_value = 8'h00;
            1: address_value = 8'hFF;
            AddressPhases - 1: address_value = AddrAtReset;
            default: address_value = 8'($urandom_range(0, 255));
         endcase
         upper = $urandom();
         csr_access(1'b1, SlaveAddrOffset, {upper[31:8], address_value}, unused);
         // writes to the unused slot must leave the address alone
         if (p % 2 == 1) csr_access(1'b1, SpareRegOffset, $urandom(), unused);
         check_slave_address();
         queue_random(RandomPerPhase);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb_modbus_rtu_request_framer OK");
      end else begin
         $display("tb_modbus_rtu_request_framer NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_modbus_rtu_request_framer NOT OK");
      $finish;
   end

endmodule
